// ----- sv/fftd_pkg.sv -----
// Package for the 0xFF-terminated frame response decoder.
// Holds the transaction payload types, operation codes and byte constants.
// No dependencies.
`default_nettype none

package fftd_pkg;

	// operation codes
	localparam logic OP_BYTE     = 1'b0;
	localparam logic OP_LINE_ERR = 1'b1;

	localparam logic [7:0] FF_BYTE       = 8'hFF;
	localparam logic [7:0] RESP_ZEROS    = 8'h33;
	localparam logic [7:0] SEL_LOW       = 8'h01;
	localparam logic [7:0] SEL_HIGH      = 8'h06;
	localparam logic [7:0] PAGE_BYTE     = 8'h10;
	localparam logic [7:0] PAGE_VALUE    = 8'h64;
	localparam logic [3:0] SIG_LIMIT     = 4'd10;
	localparam logic [3:0] SIG_KEEP      = 4'd3;
	localparam logic [1:0] RUN_LAST      = 2'd2;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       byte_stored;
		logic [5:0] store_index;
		logic [7:0] store_data;
		logic       overflow_drop;
		logic       frame_done;
		logic [5:0] frame_length;
		logic [7:0] response_code;
	} result_t;

	// what the response decode looks at when a frame ends
	typedef struct packed {
		logic [3:0] sig_count;
		logic [7:0] sig0;
		logic [7:0] sig1;
		logic [7:0] sig2;
		logic [7:0] frame_byte_one;
		logic [7:0] frame_byte_two;
		logic [7:0] response;
	} decode_in_t;

endpackage

`default_nettype wire

// ----- sv/fftd_decode.sv -----
// Response decode for a finished frame.
// Depends on fftd_pkg for decode_in_t and the byte constants.
`default_nettype none

module fftd_decode import fftd_pkg::*; (
	input  decode_in_t  dec,
	output logic [7:0]  response
);

	logic many_sig;

	assign many_sig = dec.sig_count >= SIG_KEEP;

	always_comb begin
		response = dec.response;
		unique case (dec.sig_count)
			4'd1: begin
				response = dec.sig0;
			end
			4'd2: begin
				response = (dec.sig0 == 8'h00) ? dec.sig1 : dec.sig0;
			end
			4'd5: begin
				if (dec.sig0 == 8'h00 && dec.sig1 == 8'h00 && dec.sig2 == 8'h00) begin
					response = RESP_ZEROS;
				end
			end
			default: begin
			end
		endcase
		// frame bytes override the significant-byte result
		if (many_sig && dec.frame_byte_one == SEL_LOW) begin
			if (dec.frame_byte_two >= SEL_LOW && dec.frame_byte_two <= SEL_HIGH) begin
				response = dec.frame_byte_two;
			end
		end else if (many_sig && dec.frame_byte_one == PAGE_BYTE &&
				dec.frame_byte_two == PAGE_VALUE) begin
			response = PAGE_VALUE;
		end
	end

endmodule

`default_nettype wire

// ----- sv/fftd_tracker.sv -----
// Frame state tracker: write position, 0xFF run, significant bytes, frame bytes.
// Builds the result of each accepted transaction. Depends on fftd_pkg, fftd_decode.
`default_nettype none

module fftd_tracker import fftd_pkg::*; #(
	parameter int RX_STORE_SIZE = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  item_t   item,
	output result_t result_next
);

	localparam int PosW = $clog2(RX_STORE_SIZE);
	localparam logic [PosW-1:0] LastPos = PosW'(RX_STORE_SIZE - 1);

	logic [PosW-1:0] wr_pos_q, wr_pos_n;
	logic [1:0]      ff_run_q, ff_run_n;
	logic [3:0]      sig_cnt_q, sig_cnt_n;
	logic [7:0]      sig_q [3];
	logic [7:0]      sig_n [3];
	logic [7:0]      fb1_q, fb1_n;
	logic [7:0]      fb2_q, fb2_n;
	logic [7:0]      resp_q, resp_n;

	logic            is_byte, has_room, is_ff, stored, done;
	logic [PosW-1:0] start;
	decode_in_t      dec;
	logic [7:0]      dec_resp;

	assign is_byte  = item.operation == OP_BYTE;
	assign has_room = wr_pos_q < LastPos;
	assign is_ff    = item.rx_byte == FF_BYTE;
	assign stored   = is_byte && has_room;
	assign done     = stored && is_ff && ff_run_q == RUN_LAST;
	// marker began two positions before the one written now
	assign start    = (wr_pos_q >= PosW'(2)) ? wr_pos_q - PosW'(2) : '0;

	always_comb begin
		wr_pos_n  = wr_pos_q;
		ff_run_n  = ff_run_q;
		sig_cnt_n = sig_cnt_q;
		sig_n     = sig_q;
		fb1_n     = fb1_q;
		fb2_n     = fb2_q;
		if (!stored) begin
			// line error or full store: restart position and run
			wr_pos_n = '0;
			ff_run_n = '0;
		end else begin
			wr_pos_n = wr_pos_q + PosW'(1);
			if (wr_pos_q == PosW'(1)) begin
				fb1_n = item.rx_byte;
			end else if (wr_pos_q == PosW'(2)) begin
				fb2_n = item.rx_byte;
			end
			if (is_ff) begin
				ff_run_n = ff_run_q + 2'd1;
			end else begin
				ff_run_n = '0;
				if (sig_cnt_q < SIG_LIMIT) begin
					if (sig_cnt_q < SIG_KEEP) begin
						sig_n[sig_cnt_q[1:0]] = item.rx_byte;
					end
					sig_cnt_n = sig_cnt_q + 4'd1;
				end
			end
			if (done) begin
				// zero the frame byte where the marker began
				if (start == PosW'(1)) begin
					fb1_n = 8'h00;
				end else if (start == PosW'(2)) begin
					fb2_n = 8'h00;
				end
				wr_pos_n  = '0;
				ff_run_n  = '0;
				sig_cnt_n = '0;
			end
		end
	end

	always_comb begin
		dec.sig_count      = sig_cnt_q;
		dec.sig0           = sig_q[0];
		dec.sig1           = sig_q[1];
		dec.sig2           = sig_q[2];
		dec.frame_byte_one = fb1_n;
		dec.frame_byte_two = fb2_n;
		dec.response       = resp_q;
	end

	fftd_decode u_decode (
		.dec      (dec),
		.response (dec_resp)
	);

	assign resp_n = done ? dec_resp : resp_q;

	always_comb begin
		result_next.byte_stored   = stored;
		result_next.store_index   = stored ? 6'(wr_pos_q) : 6'd0;
		result_next.store_data    = stored ? item.rx_byte : 8'h00;
		result_next.overflow_drop = is_byte && !has_room;
		result_next.frame_done    = done;
		result_next.frame_length  = done ? 6'(start) : 6'd0;
		result_next.response_code = resp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q  <= '0;
			ff_run_q  <= '0;
			sig_cnt_q <= '0;
			sig_q[0]  <= '0;
			sig_q[1]  <= '0;
			sig_q[2]  <= '0;
			fb1_q     <= '0;
			fb2_q     <= '0;
			resp_q    <= '0;
		end else if (load) begin
			wr_pos_q  <= wr_pos_n;
			ff_run_q  <= ff_run_n;
			sig_cnt_q <= sig_cnt_n;
			sig_q     <= sig_n;
			fb1_q     <= fb1_n;
			fb2_q     <= fb2_n;
			resp_q    <= resp_n;
		end
	end

endmodule

`default_nettype wire

// ----- sv/fftd_out_reg.sv -----
// Result register with valid/ready handshake toward the consumer.
// Depends on fftd_pkg for result_t.
`default_nettype none

module fftd_out_reg import fftd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result_next,
	output logic    can_load,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    valid_q;
	result_t data_q;

	// take a new transaction when empty or when the held one leaves now
	assign can_load     = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result_next;
		end
	end

endmodule

`default_nettype wire

// ----- sv/ff_terminated_frame_response_decoder_core.sv -----
// Top level of the 0xFF-terminated frame response decoder.
// Depends on fftd_pkg, fftd_tracker, fftd_out_reg.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------
//  item     | item_valid / item_ready     | item   (item_t)
//  result   | result_valid / result_ready | result (result_t)
//
// One transaction per cycle unless stalled; results show in the next cycle,
// set by the single result register behind the state update and decode.
// item_ready is high whenever the result register is empty or being drained.
// A stalled result holds in the register and blocks only new acceptance.
// Reset clears all frame state and the result valid flag at once.
`default_nettype none

module ff_terminated_frame_response_decoder_core import fftd_pkg::*; #(
	parameter int RX_STORE_SIZE = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    load;
	result_t result_next;

	assign load = item_valid && item_ready;

	fftd_tracker #(
		.RX_STORE_SIZE (RX_STORE_SIZE)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.item        (item),
		.result_next (result_next)
	);

	fftd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.result_next  (result_next),
		.can_load     (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// ----- sv/fftd_checker.sv -----
// Port-level checker for the frame response decoder, bound to the top level.
// Depends on fftd_pkg and ff_terminated_frame_response_decoder_core.
`default_nettype none

module fftd_checker import fftd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// an empty output never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input blocked with empty output");

	// every accepted transaction shows a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted transaction produced no result");

	// a frame end comes from a stored 0xFF byte
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_done |->
			result.byte_stored && result.store_data == FF_BYTE && !result.overflow_drop)
		else $error("frame end without stored 0xFF");

endmodule

bind ff_terminated_frame_response_decoder_core fftd_checker u_fftd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
